// File: hdl/ezalloc_pkg.sv
// ----------------------------------------------------------------------------
// Empty zone allocator package
// Shared codes and default sizes for the zone allocator.
// ----------------------------------------------------------------------------
package ezalloc_pkg;

    localparam int NUM_ZONES_DEF = 64;
    localparam int WEAR_BITS_DEF = 16;

    localparam int REQ_W    = 2;
    localparam int SEL_W    = 6;
    localparam int WEAR_IN_W = 16;
    localparam int ZONE_W   = 6;
    localparam int POLICY_W = 2;
    localparam int ACTIVE_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_STATUS  = 2'd2
    } t_req_type;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_LEAST = 2'd2
    } t_policy;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALLOC_POLICY = 1'd0,
        CFG_ACTIVE_ZONES = 1'd1
    } t_cfg_index;

endpackage

// File: hdl/ezalloc_zone_ram.sv
// ----------------------------------------------------------------------------
// Zone table memory
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module ezalloc_zone_ram #(
    parameter int DEPTH = ezalloc_pkg::NUM_ZONES_DEF,
    parameter int WIDTH = ezalloc_pkg::WEAR_BITS_DEF + 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/empty_zone_allocator_core.sv
// ----------------------------------------------------------------------------
// Empty zone allocator core
// Grants free, empty zones by first fit, next fit or least wear.
// ----------------------------------------------------------------------------
// Each zone keeps a busy flag, an empty flag and a wear count in one table
// memory that is read one zone per cycle. An allocate item scans the active
// zones through that single read port; first fit and next fit stop at the
// first free, empty zone, while least wear scans them all. A found zone is
// marked busy in a write step before the result is registered; when nothing
// is granted, the result is registered without that step. Release and status
// items do a read-modify-write of one zone in a read step and a modify step
// before their result is registered. The next item is taken in the cycle
// after the result is registered; a stalled result holds the block in its
// final step until the output register frees up. After reset the table is
// swept to its reset contents; no item is accepted during the sweep.
module empty_zone_allocator_core #(
    parameter int NUM_ZONES = ezalloc_pkg::NUM_ZONES_DEF,
    parameter int WEAR_BITS = ezalloc_pkg::WEAR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_we,
    input  logic [ezalloc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ezalloc_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ezalloc_pkg::REQ_W-1:0]       i_req_type,
    input  logic [ezalloc_pkg::SEL_W-1:0]       i_zone_sel,
    input  logic                                i_empty_in,
    input  logic [ezalloc_pkg::WEAR_IN_W-1:0]   i_wear_in,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_granted,
    output logic [ezalloc_pkg::ZONE_W-1:0]      o_zone_idx
);

    localparam int ZW = $clog2(NUM_ZONES);
    localparam int NW = $clog2(NUM_ZONES + 1);
    localparam int EW = WEAR_BITS + 2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_MODIFY,
        ST_MARK,
        ST_DONE
    } t_state;

    t_state                           r_state;
    logic [ezalloc_pkg::POLICY_W-1:0] r_policy;
    logic [ezalloc_pkg::ACTIVE_W-1:0] r_active_zones;

    logic [ZW-1:0]                    r_clr_addr;
    logic [ZW-1:0]                    r_ptr;
    logic [ZW-1:0]                    r_start;
    logic [ZW-1:0]                    r_addr;
    logic [ZW-1:0]                    r_paddr;
    logic [ZW-1:0]                    r_pick;
    logic [ZW-1:0]                    r_sel_idx;
    logic [NW-1:0]                    r_n;
    logic [NW-1:0]                    r_issued;
    logic                             r_pend;
    logic                             r_got;
    logic [WEAR_BITS-1:0]             r_best_wear;
    logic [ezalloc_pkg::REQ_W-1:0]    r_req;
    logic                             r_empty_in;
    logic [WEAR_BITS-1:0]             r_wear_in;

    logic                             r_out_valid;
    logic                             r_granted;
    logic [ezalloc_pkg::ZONE_W-1:0]   r_zone_idx;

    logic [NW-1:0]                    n_lim;
    logic [ZW-1:0]                    n_start;
    logic                             pol_next;
    logic                             pol_least;
    logic                             in_accept;
    logic                             out_free;

    logic                             ram_we;
    logic [ZW-1:0]                    ram_waddr;
    logic [EW-1:0]                    ram_wdata;
    logic [ZW-1:0]                    ram_raddr;
    logic [EW-1:0]                    ram_rdata;

    logic                             rd_busy;
    logic                             rd_empty;
    logic [WEAR_BITS-1:0]             rd_wear;
    logic                             rd_elig;

    function automatic logic [ZW-1:0] f_wrap(input logic [ZW-1:0] z, input logic [NW-1:0] n);
        logic [NW-1:0] zi;
        zi = NW'(z) + NW'(1);
        return (zi >= n) ? '0 : ZW'(zi);
    endfunction

    ezalloc_zone_ram #(
        .DEPTH (NUM_ZONES),
        .WIDTH (EW)
    ) u_zone_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_busy  = ram_rdata[EW-1];
    assign rd_empty = ram_rdata[EW-2];
    assign rd_wear  = ram_rdata[WEAR_BITS-1:0];
    assign rd_elig  = !rd_busy && rd_empty;

    assign pol_next  = (r_policy == ezalloc_pkg::POL_NEXT);
    assign pol_least = (r_policy == ezalloc_pkg::POL_LEAST);

    assign n_lim = (32'(r_active_zones) > 32'(NUM_ZONES)) ? NW'(NUM_ZONES)
                                                          : NW'(r_active_zones);
    assign n_start = (pol_next && (NW'(r_ptr) < n_lim)) ? r_ptr : '0;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign ram_raddr = (r_state == ST_SCAN) ? r_addr : r_sel_idx;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_sel_idx;
        ram_wdata = {1'b0, 1'b1, {WEAR_BITS{1'b0}}};
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
            end
            ST_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = r_pick;
                ram_wdata = {1'b1, 1'b1, r_best_wear};
            end
            ST_MODIFY: begin
                ram_we = 1'b1;
                if (r_req == ezalloc_pkg::REQ_RELEASE) begin
                    ram_wdata = {1'b0, rd_empty, rd_wear};
                end else begin
                    ram_wdata = {rd_busy, r_empty_in, r_wear_in};
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy       <= ezalloc_pkg::POL_FIRST;
            r_active_zones <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ezalloc_pkg::CFG_ALLOC_POLICY: r_policy <= i_cfg_data[1:0];
                ezalloc_pkg::CFG_ACTIVE_ZONES: r_active_zones <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_got       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ZW'(1);
                    if (r_clr_addr == ZW'(NUM_ZONES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        r_req      <= i_req_type;
                        r_sel_idx  <= ZW'(i_zone_sel);
                        r_empty_in <= i_empty_in;
                        r_wear_in  <= WEAR_BITS'(i_wear_in);
                        r_got      <= 1'b0;
                        r_pend     <= 1'b0;
                        r_issued   <= '0;
                        r_n        <= n_lim;
                        r_addr     <= n_start;
                        r_start    <= n_start;
                        r_pick     <= '0;
                        priority if (i_req_type == ezalloc_pkg::REQ_ALLOC) begin
                            r_state <= (n_lim == '0) ? ST_DONE : ST_SCAN;
                        end else if ((i_req_type == ezalloc_pkg::REQ_RELEASE ||
                                      i_req_type == ezalloc_pkg::REQ_STATUS) &&
                                     (32'(i_zone_sel) < 32'(NUM_ZONES))) begin
                            r_state <= ST_READ;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_pend && rd_elig && !pol_least) begin
                        r_got       <= 1'b1;
                        r_pick      <= r_paddr;
                        r_best_wear <= rd_wear;
                        r_pend      <= 1'b0;
                        if (pol_next) begin
                            r_ptr <= f_wrap(r_paddr, r_n);
                        end
                        r_state <= ST_MARK;
                    end else begin
                        if (r_pend && rd_elig && (!r_got || rd_wear <= r_best_wear)) begin
                            r_got       <= 1'b1;
                            r_pick      <= r_paddr;
                            r_best_wear <= rd_wear;
                        end
                        if (r_issued < r_n) begin
                            r_paddr  <= r_addr;
                            r_addr   <= f_wrap(r_addr, r_n);
                            r_issued <= r_issued + NW'(1);
                            r_pend   <= 1'b1;
                        end else begin
                            r_pend <= 1'b0;
                            if (!r_pend) begin
                                if (pol_next) begin
                                    r_ptr <= r_start;
                                end
                                r_state <= r_got ? ST_MARK : ST_DONE;
                            end
                        end
                    end
                end
                ST_READ: begin
                    r_state <= ST_MODIFY;
                end
                ST_MODIFY: begin
                    r_state <= ST_DONE;
                end
                ST_MARK: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_granted   <= r_got;
                        r_zone_idx  <= r_got ? ezalloc_pkg::ZONE_W'(r_pick) : '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_granted   = r_granted;
    assign o_zone_idx  = r_zone_idx;

    a_no_grant_zero_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted) |-> (o_zone_idx == '0))
        else $error("zone index set on a result without grant");

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while previous item still in work");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_issued <= r_n))
        else $error("scan went past the active zone count");

endmodule
